// ----- design/ket_pkg.sv -----
// ----------------------------------------------------------------------------
// ket_pkg
// Types and codes shared by the keyed expiry timer table.
// ----------------------------------------------------------------------------
package ket_pkg;

   localparam int KeyW  = 16;
   localparam int TimeW = 32;
   localparam int MagW  = 32;
   localparam int FuncW = 3;
   localparam int ResW  = 3;

   typedef enum logic [FuncW-1:0] {
      FUNC_APPLY  = 3'd0,
      FUNC_REMOVE = 3'd1,
      FUNC_CLEAR  = 3'd2,
      FUNC_TICK   = 3'd3,
      FUNC_QUERY  = 3'd4
   } func_type;

   typedef enum logic [ResW-1:0] {
      RES_APPLIED = 3'd0,
      RES_REMOVED = 3'd1,
      RES_PRESENT = 3'd2,
      RES_ABSENT  = 3'd3,
      RES_FULL    = 3'd4
   } res_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_TICK,
      ST_CLEAR,
      ST_COMPACT,
      ST_APPEND,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      res_type              res;
      logic [KeyW-1:0]      key;
      logic [TimeW-1:0]     dur;
      logic [MagW-1:0]      mag;
   } ket_evt_type;

   typedef struct packed {
      logic        push;
      logic        flush;
      ket_evt_type evt;
   } ket_emit_ctl_type;

   typedef struct packed {
      logic push_ok;
      logic hold_empty;
   } ket_emit_sts_type;

endpackage

// ----- design/ket_store.sv -----
// ----------------------------------------------------------------------------
// ket_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ket_store import ket_pkg::*; #(
   parameter int DEPTH = 16,
   parameter int KEY_W = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [KEY_W-1:0]         wr_key,
   input  logic [TimeW-1:0]         wr_time,
   input  logic [MagW-1:0]          wr_mag,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [KEY_W-1:0]         rd_key,
   output logic [TimeW-1:0]         rd_time,
   output logic [MagW-1:0]          rd_mag
);

   logic [KEY_W-1:0] key_mem [DEPTH];
   logic [TimeW-1:0] time_mem [DEPTH];
   logic [MagW-1:0]  mag_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]  <= wr_key;
         time_mem[wr_addr] <= wr_time;
         mag_mem[wr_addr]  <= wr_mag;
      end
   end

   always_ff @(posedge clock) begin
      rd_key  <= key_mem[rd_addr];
      rd_time <= time_mem[rd_addr];
      rd_mag  <= mag_mem[rd_addr];
   end

endmodule

// ----- design/ket_alu.sv -----
// ----------------------------------------------------------------------------
// ket_alu
// Shared key compare and time subtract/expiry test for the entry scans.
// ----------------------------------------------------------------------------
module ket_alu import ket_pkg::*; #(
   parameter int KEY_W = 16
) (
   input  logic [KEY_W-1:0] ent_key,
   input  logic [TimeW-1:0] ent_time,
   input  logic [KEY_W-1:0] key,
   input  logic [TimeW-1:0] step,
   output logic             key_eq,
   output logic             expire,
   output logic [TimeW-1:0] time_left
);

   logic [TimeW:0] diff;

   assign diff      = {1'b0, ent_time} - {1'b0, step};
   assign key_eq    = (ent_key == key);
   // borrow or exact zero: time <= step
   assign expire    = diff[TimeW] | (diff[TimeW-1:0] == '0);
   assign time_left = diff[TimeW-1:0];

endmodule

// ----- design/ket_emit.sv -----
// ----------------------------------------------------------------------------
// ket_emit
// Result staging: a hold slot that tags the final result, then the output
// register towards the response channel.
// ----------------------------------------------------------------------------
module ket_emit import ket_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  ket_emit_ctl_type  ctl,
   output ket_emit_sts_type  sts,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ResW-1:0]   rsp_event_res,
   output logic [KeyW-1:0]   rsp_event_key,
   output logic [TimeW-1:0]  rsp_event_duration,
   output logic [MagW-1:0]   rsp_event_magnitude,
   output logic              rsp_last
);

   logic        hold_vld_ff, hold_vld_in;
   ket_evt_type hold_ff, hold_in;
   logic        out_vld_ff, out_vld_in;
   ket_evt_type out_ff, out_in;
   logic        last_ff, last_in;
   logic        out_free;
   logic        move;

   assign out_free = !out_vld_ff || !rsp_stall;
   assign move     = hold_vld_ff && out_free && (ctl.push || ctl.flush);

   always_comb begin
      hold_vld_in = hold_vld_ff;
      hold_in     = hold_ff;
      out_vld_in  = out_vld_ff && rsp_stall;
      out_in      = out_ff;
      last_in     = last_ff;
      if (move) begin
         out_vld_in = 1'b1;
         out_in     = hold_ff;
         last_in    = ctl.flush;
         hold_vld_in = 1'b0;
      end
      if (ctl.push && (!hold_vld_ff || out_free)) begin
         hold_vld_in = 1'b1;
         hold_in     = ctl.evt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         hold_vld_ff <= hold_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      out_ff  <= out_in;
      last_ff <= last_in;
   end

   assign sts.push_ok    = !hold_vld_ff || out_free;
   assign sts.hold_empty = !hold_vld_ff;

   assign rsp_valid           = out_vld_ff;
   assign rsp_event_res       = out_ff.res;
   assign rsp_event_key       = out_ff.key;
   assign rsp_event_duration  = out_ff.dur;
   assign rsp_event_magnitude = out_ff.mag;
   assign rsp_last            = last_ff;

endmodule

// ----- design/keyed_expiry_timer_table.sv -----
// ----------------------------------------------------------------------------
// keyed_expiry_timer_table
// Ordered table of timed, keyed entries with apply, remove, clear, tick and
// query operations, sequenced over an entry memory with one write and one read port.
// ----------------------------------------------------------------------------
// One request is handled at a time; req_stall stays high until its last
// result has been staged. Every scan reads one entry per cycle from the entry
// memory's single read port, except while the response side holds it off. A
// result may wait in the output register while the next request is taken.
// Memory contents need no clearing after reset; of the table, only the entry
// count is reset.
module keyed_expiry_timer_table import ket_pkg::*; #(
   parameter int TABLE_DEPTH = 16,
   parameter int KEY_BITS    = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [FuncW-1:0]  req_func,
   input  logic [KeyW-1:0]   req_key,
   input  logic [TimeW-1:0]  req_duration,
   input  logic [MagW-1:0]   req_magnitude,
   input  logic [TimeW-1:0]  req_step_time,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ResW-1:0]   rsp_event_res,
   output logic [KeyW-1:0]   rsp_event_key,
   output logic [TimeW-1:0]  rsp_event_duration,
   output logic [MagW-1:0]   rsp_event_magnitude,
   output logic              rsp_last
);

   localparam int IW  = $clog2(TABLE_DEPTH);
   localparam int CW  = $clog2(TABLE_DEPTH + 1);
   localparam int SkW = (KEY_BITS < KeyW) ? KEY_BITS : KeyW;

   state_type        state_ff, state_in;
   logic             authority_ff;
   logic [CW-1:0]    cnt_ff, cnt_in;
   func_type         func_ff, func_in;
   logic [SkW-1:0]   key_ff, key_in;
   logic [TimeW-1:0] dur_ff, dur_in;
   logic [MagW-1:0]  mag_ff, mag_in;
   logic [TimeW-1:0] step_ff, step_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [IW-1:0]    rd_idx_ff, rd_idx_in;
   logic [CW-1:0]    iss_ff, iss_in;
   logic [CW-1:0]    wp_ff, wp_in;

   logic             wr_en;
   logic [IW-1:0]    wr_addr;
   logic [SkW-1:0]   wr_key;
   logic [TimeW-1:0] wr_time;
   logic [MagW-1:0]  wr_mag;
   logic [IW-1:0]    rd_addr;
   logic [SkW-1:0]   rd_key;
   logic [TimeW-1:0] rd_time;
   logic [MagW-1:0]  rd_mag;

   logic             alu_key_eq;
   logic             alu_expire;
   logic [TimeW-1:0] alu_left;

   ket_emit_ctl_type emit_ctl;
   ket_emit_sts_type emit_sts;

   logic             accept;
   logic             srch_done;
   logic             srch_hit;
   logic             keep;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      func_in   = func_ff;
      key_in    = key_ff;
      dur_in    = dur_ff;
      mag_in    = mag_ff;
      step_in   = step_ff;
      rd_vld_in = rd_vld_ff;
      rd_idx_in = rd_idx_ff;
      iss_in    = iss_ff;
      wp_in     = wp_ff;
      rd_addr   = rd_idx_ff;
      wr_en     = 1'b0;
      wr_addr   = wp_ff[IW-1:0];
      wr_key    = rd_key;
      wr_time   = rd_time;
      wr_mag    = rd_mag;
      srch_done = 1'b0;
      srch_hit  = 1'b0;
      keep      = 1'b0;
      emit_ctl.push      = 1'b0;
      emit_ctl.flush     = 1'b0;
      emit_ctl.evt.res   = RES_REMOVED;
      emit_ctl.evt.key   = KeyW'(rd_key);
      emit_ctl.evt.dur   = '0;
      emit_ctl.evt.mag   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in   = func_type'(req_func);
               key_in    = req_key[SkW-1:0];
               dur_in    = req_duration;
               mag_in    = req_magnitude;
               step_in   = req_step_time;
               rd_vld_in = (cnt_ff != '0);
               rd_idx_in = IW'(cnt_ff - CW'(1));
               rd_addr   = IW'(cnt_ff - CW'(1));
               case (func_type'(req_func))
                  FUNC_QUERY: state_in = ST_SEARCH;
                  FUNC_APPLY,
                  FUNC_REMOVE: state_in = authority_ff ? ST_SEARCH : ST_FLUSH;
                  FUNC_TICK:   state_in = authority_ff ? ST_TICK : ST_FLUSH;
                  FUNC_CLEAR: begin
                     rd_idx_in = '0;
                     rd_addr   = '0;
                     state_in  = authority_ff ? ST_CLEAR : ST_FLUSH;
                  end
                  default: state_in = ST_FLUSH;
               endcase
            end
         end

         ST_SEARCH: begin
            if (!rd_vld_ff) begin
               srch_done = 1'b1;
            end else if (alu_key_eq) begin
               srch_done = 1'b1;
               srch_hit  = 1'b1;
            end else if (rd_idx_ff == '0) begin
               srch_done = 1'b1;
            end else begin
               rd_addr   = rd_idx_ff - IW'(1);
               rd_idx_in = rd_idx_ff - IW'(1);
            end
            if (srch_done) begin
               rd_vld_in        = 1'b0;
               emit_ctl.evt.key = KeyW'(key_ff);
               iss_in           = CW'(rd_idx_ff) + CW'(1);
               wp_in            = CW'(rd_idx_ff);
               case (func_ff)
                  FUNC_QUERY: begin
                     emit_ctl.push    = 1'b1;
                     emit_ctl.evt.res = srch_hit ? RES_PRESENT : RES_ABSENT;
                     state_in         = ST_FLUSH;
                  end
                  FUNC_REMOVE: begin
                     emit_ctl.push    = srch_hit;
                     emit_ctl.evt.res = RES_REMOVED;
                     state_in         = srch_hit ? ST_COMPACT : ST_FLUSH;
                  end
                  FUNC_APPLY: begin
                     if (srch_hit) begin
                        state_in = ST_COMPACT;
                     end else if (cnt_ff == CW'(TABLE_DEPTH)) begin
                        emit_ctl.push    = 1'b1;
                        emit_ctl.evt.res = RES_FULL;
                        state_in         = ST_FLUSH;
                     end else begin
                        state_in = ST_APPEND;
                     end
                  end
                  default: state_in = ST_FLUSH;
               endcase
            end
         end

         ST_TICK: begin
            if (!rd_vld_ff) begin
               iss_in   = '0;
               wp_in    = '0;
               state_in = ST_COMPACT;
            end else if (alu_expire && !emit_sts.push_ok) begin
               rd_addr = rd_idx_ff;
            end else begin
               emit_ctl.push = alu_expire;
               if (rd_idx_ff == '0) begin
                  rd_vld_in = 1'b0;
                  iss_in    = '0;
                  wp_in     = '0;
                  state_in  = ST_COMPACT;
               end else begin
                  rd_addr   = rd_idx_ff - IW'(1);
                  rd_idx_in = rd_idx_ff - IW'(1);
               end
            end
         end

         ST_CLEAR: begin
            if (!rd_vld_ff) begin
               cnt_in   = '0;
               state_in = ST_FLUSH;
            end else if (emit_sts.push_ok) begin
               emit_ctl.push = 1'b1;
               if (CW'(rd_idx_ff) + CW'(1) == cnt_ff) begin
                  cnt_in    = '0;
                  rd_vld_in = 1'b0;
                  state_in  = ST_FLUSH;
               end else begin
                  rd_addr   = rd_idx_ff + IW'(1);
                  rd_idx_in = rd_idx_ff + IW'(1);
               end
            end
         end

         ST_COMPACT: begin
            if (rd_vld_ff) begin
               keep = (func_ff != FUNC_TICK) || !alu_expire;
               if (keep) begin
                  wr_en   = 1'b1;
                  wr_time = (func_ff == FUNC_TICK) ? alu_left : rd_time;
                  wp_in   = wp_ff + CW'(1);
               end
            end
            if (iss_ff < cnt_ff) begin
               rd_addr   = iss_ff[IW-1:0];
               rd_idx_in = iss_ff[IW-1:0];
               rd_vld_in = 1'b1;
               iss_in    = iss_ff + CW'(1);
            end else begin
               rd_vld_in = 1'b0;
               if (!rd_vld_ff) begin
                  cnt_in   = wp_ff;
                  state_in = (func_ff == FUNC_APPLY) ? ST_APPEND : ST_FLUSH;
               end
            end
         end

         ST_APPEND: begin
            wr_en            = 1'b1;
            wr_addr          = cnt_ff[IW-1:0];
            wr_key           = key_ff;
            wr_time          = dur_ff;
            wr_mag           = mag_ff;
            cnt_in           = cnt_ff + CW'(1);
            emit_ctl.push    = 1'b1;
            emit_ctl.evt.res = RES_APPLIED;
            emit_ctl.evt.key = KeyW'(key_ff);
            emit_ctl.evt.dur = dur_ff;
            emit_ctl.evt.mag = mag_ff;
            state_in         = ST_FLUSH;
         end

         ST_FLUSH: begin
            emit_ctl.flush = !emit_sts.hold_empty;
            if (emit_sts.hold_empty) begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         authority_ff <= 1'b1;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         rd_vld_ff <= rd_vld_in;
         if (csr_wr_en) begin
            authority_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      key_ff    <= key_in;
      dur_ff    <= dur_in;
      mag_ff    <= mag_in;
      step_ff   <= step_in;
      rd_idx_ff <= rd_idx_in;
      iss_ff    <= iss_in;
      wp_ff     <= wp_in;
   end

   ket_store #(
      .DEPTH (TABLE_DEPTH),
      .KEY_W (SkW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_key  (wr_key),
      .wr_time (wr_time),
      .wr_mag  (wr_mag),
      .rd_addr (rd_addr),
      .rd_key  (rd_key),
      .rd_time (rd_time),
      .rd_mag  (rd_mag)
   );

   ket_alu #(
      .KEY_W (SkW)
   ) u_alu (
      .ent_key   (rd_key),
      .ent_time  (rd_time),
      .key       (key_ff),
      .step      (step_ff),
      .key_eq    (alu_key_eq),
      .expire    (alu_expire),
      .time_left (alu_left)
   );

   ket_emit u_emit (
      .clock               (clock),
      .reset               (reset),
      .ctl                 (emit_ctl),
      .sts                 (emit_sts),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_event_res       (rsp_event_res),
      .rsp_event_key       (rsp_event_key),
      .rsp_event_duration  (rsp_event_duration),
      .rsp_event_magnitude (rsp_event_magnitude),
      .rsp_last            (rsp_last)
   );

   a_cnt_bound : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("request channel not stalled after a transfer");

   a_compact_order : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMPACT && rd_vld_ff) |-> (wp_ff <= CW'(rd_idx_ff)))
      else $error("compaction write pointer ahead of read index");

   a_idle_hold_empty : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> emit_sts.hold_empty)
      else $error("result left in hold slot while idle");

endmodule

// ----- test/tb_keyed_expiry_timer_table.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyed_expiry_timer_table
// Self-checking bench for the keyed expiry timer table. A queue of requests
// feeds a clocked driver. Each request that the block takes updates a local
// copy of the table and queues the events it should raise. A clocked monitor
// compares every returned event with the oldest queued one. Both sides idle at
// random, and the response side holds off once for a long stretch. The run
// covers the table corner cases and authority on, off and on again.
// ----------------------------------------------------------------------------
module tb_keyed_expiry_timer_table import ket_pkg::*;;

   localparam int CLOCK_HALF       = 5;
   localparam int RESET_CYCLES     = 12;
   localparam int TABLE_DEPTH      = 16;
   localparam int KEY_BITS         = 16;
   localparam int DRAIN_CYCLES     = 64;
   localparam int LONG_HOLD_CYCLES = 150;
   localparam int WATCHDOG_LIMIT   = 3000;
   localparam logic [KeyW-1:0]  KEY_POOL_BASE     = 16'h0A50;
   localparam logic [FuncW-1:0] FUNC_UNUSED_FIRST = 3'd5;
   localparam logic [FuncW-1:0] FUNC_UNUSED_LAST  = 3'd7;

   typedef struct {
      logic [FuncW-1:0] func;
      logic [KeyW-1:0]  key;
      logic [TimeW-1:0] duration;
      logic [MagW-1:0]  magnitude;
      logic [TimeW-1:0] step_time;
   } table_req_type;

   typedef struct {
      res_type          res;
      logic [KeyW-1:0]  key;
      logic [TimeW-1:0] dur;
      logic [MagW-1:0]  mag;
      logic             last;
   } table_event_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_wr_en = 1'b0;
   logic             csr_wr_data = 1'b0;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [FuncW-1:0] req_func = '0;
   logic [KeyW-1:0]  req_key = '0;
   logic [TimeW-1:0] req_duration = '0;
   logic [MagW-1:0]  req_magnitude = '0;
   logic [TimeW-1:0] req_step_time = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [ResW-1:0]  rsp_event_res;
   logic [KeyW-1:0]  rsp_event_key;
   logic [TimeW-1:0] rsp_event_duration;
   logic [MagW-1:0]  rsp_event_magnitude;
   logic             rsp_last;

   // local copy of the table
   logic             auth_model = 1'b1;
   int               tab_count = 0;
   logic [KeyW-1:0]  tab_key  [TABLE_DEPTH];
   logic [TimeW-1:0] tab_time [TABLE_DEPTH];
   logic [MagW-1:0]  tab_mag  [TABLE_DEPTH];

   table_req_type   pending_reqs[$];
   table_event_type expected_events[$];
   table_req_type   req_cur;
   table_event_type rsp_want;

   int   req_gap = 0;
   int   rsp_gap = 0;
   int   hold_left = 0;
   bit   no_idle = 1'b0;
   bit   want_long_hold = 1'b0;
   bit   long_hold_done = 1'b0;
   int   idle_cycles = 0;
   int   fail_count = 0;
   int   reqs_accepted = 0;
   int   events_checked = 0;
   int   removals_seen = 0;
   int   full_seen = 0;
   int   queries_seen = 0;

   keyed_expiry_timer_table #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .KEY_BITS(KEY_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_key(req_key),
      .req_duration(req_duration),
      .req_magnitude(req_magnitude),
      .req_step_time(req_step_time),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_event_res(rsp_event_res),
      .rsp_event_key(rsp_event_key),
      .rsp_event_duration(rsp_event_duration),
      .rsp_event_magnitude(rsp_event_magnitude),
      .rsp_last(rsp_last)
   );

   always #CLOCK_HALF clock = ~clock;

   // ---- table prediction ----
   function automatic int find_newest(logic [KeyW-1:0] key);
      for (int i = tab_count - 1; i >= 0; i--) begin
         if (tab_key[i] == key) return i;
      end
      return -1;
   endfunction

   function automatic void drop_entry(int pos);
      for (int i = pos; i + 1 < tab_count; i++) begin
         tab_key[i]  = tab_key[i + 1];
         tab_time[i] = tab_time[i + 1];
         tab_mag[i]  = tab_mag[i + 1];
      end
      tab_count--;
   endfunction

   function automatic void queue_event(res_type res, logic [KeyW-1:0] key,
                                       logic [TimeW-1:0] dur, logic [MagW-1:0] mag);
      table_event_type e;
      e.res  = res;
      e.key  = key;
      e.dur  = dur;
      e.mag  = mag;
      e.last = 1'b0;
      expected_events.push_back(e);
   endfunction

   function automatic void predict_table_op(table_req_type r);
      int pos;
      int queued_at_start;
      logic [KeyW-1:0] k;
      queued_at_start = expected_events.size();
      if (r.func == FUNC_QUERY) begin
         queue_event(find_newest(r.key) >= 0 ? RES_PRESENT : RES_ABSENT, r.key, '0, '0);
      end else if (r.func <= FUNC_TICK && auth_model) begin
         case (r.func)
            FUNC_APPLY: begin
               pos = find_newest(r.key);
               if (pos >= 0) drop_entry(pos);
               if (tab_count >= TABLE_DEPTH) begin
                  queue_event(RES_FULL, r.key, '0, '0);
               end else begin
                  tab_key[tab_count]  = r.key;
                  tab_time[tab_count] = r.duration;
                  tab_mag[tab_count]  = r.magnitude;
                  tab_count++;
                  queue_event(RES_APPLIED, r.key, r.duration, r.magnitude);
               end
            end
            FUNC_REMOVE: begin
               pos = find_newest(r.key);
               if (pos >= 0) begin
                  drop_entry(pos);
                  queue_event(RES_REMOVED, r.key, '0, '0);
               end
            end
            FUNC_CLEAR: begin
               for (int i = 0; i < tab_count; i++) queue_event(RES_REMOVED, tab_key[i], '0, '0);
               tab_count = 0;
            end
            default: begin
               // walk last to first; expired entries leave with a report
               for (int i = tab_count - 1; i >= 0; i--) begin
                  if (tab_time[i] <= r.step_time) begin
                     k = tab_key[i];
                     drop_entry(i);
                     queue_event(RES_REMOVED, k, '0, '0);
                  end else begin
                     tab_time[i] = tab_time[i] - r.step_time;
                  end
               end
            end
         endcase
      end
      if (expected_events.size() > queued_at_start)
         expected_events[expected_events.size() - 1].last = 1'b1;
   endfunction

   // ---- stimulus ----
   task automatic send(logic [FuncW-1:0] func, logic [KeyW-1:0] key, logic [TimeW-1:0] dur,
                       logic [MagW-1:0] mag, logic [TimeW-1:0] step);
      table_req_type r;
      r.func      = func;
      r.key       = key;
      r.duration  = dur;
      r.magnitude = mag;
      r.step_time = step;
      pending_reqs.push_back(r);
   endtask

   function automatic table_req_type random_req();
      table_req_type r;
      int sel;
      r.key       = $urandom_range(0, 9) == 0 ? 16'($urandom)
                                               : KEY_POOL_BASE + 16'($urandom_range(0, 19));
      r.magnitude = $urandom;
      sel = $urandom_range(0, 9);
      r.duration  = sel < 7 ? 32'($urandom_range(1, 32'h0003_0000)) :
                    sel < 9 ? 32'($urandom) : '0;
      sel = $urandom_range(0, 9);
      r.step_time = sel < 6 ? 32'($urandom_range(0, 32'h0001_8000)) :
                    sel == 6 ? '0 : sel < 9 ? 32'($urandom) : '1;
      sel = $urandom_range(0, 99);
      if (sel < 40)      r.func = FUNC_APPLY;
      else if (sel < 52) r.func = FUNC_REMOVE;
      else if (sel < 57) r.func = FUNC_CLEAR;
      else if (sel < 77) r.func = FUNC_TICK;
      else if (sel < 95) r.func = FUNC_QUERY;
      else               r.func = 3'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST));
      return r;
   endfunction

   // mostly single ops, with the odd burst of applies that can fill the table
   task automatic queue_random(int count);
      int queued;
      int burst;
      logic [KeyW-1:0] base;
      queued = 0;
      while (queued < count) begin
         if ($urandom_range(0, 9) == 0) begin
            burst = $urandom_range(8, 17);
            base  = 16'($urandom);
            for (int i = 0; i < burst; i++)
               send(FUNC_APPLY, base + 16'(i), $urandom_range(32'h0001_0000, 32'h0008_0000),
                    $urandom, $urandom);
            queued += burst;
         end else begin
            pending_reqs.push_back(random_req());
            queued++;
         end
      end
   endtask

   task automatic write_authority(logic value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      auth_model = value;
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid || expected_events.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // ---- request driver ----
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_table_op(req_cur);
            reqs_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0 && !no_idle && $urandom_range(0, 3) == 0) begin
               req_gap = $urandom_range(0, 2);
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               req_cur = pending_reqs.pop_front();
               req_func      <= req_cur.func;
               req_key       <= req_cur.key;
               req_duration  <= req_cur.duration;
               req_magnitude <= req_cur.magnitude;
               req_step_time <= req_cur.step_time;
               req_valid     <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---- result monitor ----
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               $display("%0t: unexpected transfer: expected none, actual res %0d key %0h",
                        $time, rsp_event_res, rsp_event_key);
               fail_count++;
            end else begin
               rsp_want = expected_events.pop_front();
               check_field("event_res", 32'(rsp_want.res), 32'(rsp_event_res));
               check_field("event_key", 32'(rsp_want.key), 32'(rsp_event_key));
               check_field("event_duration", rsp_want.dur, rsp_event_duration);
               check_field("event_magnitude", rsp_want.mag, rsp_event_magnitude);
               check_field("last", 32'(rsp_want.last), 32'(rsp_last));
               events_checked++;
               if (rsp_want.res == RES_REMOVED) removals_seen++;
               if (rsp_want.res == RES_FULL) full_seen++;
               if (rsp_want.res == RES_PRESENT || rsp_want.res == RES_ABSENT) queries_seen++;
            end
         end
         if (want_long_hold && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_stall <= 1'b1;
         end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            rsp_gap = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---- watchdog ----
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("** keyed_expiry_timer_table: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      write_authority(1'b1);

      send(FUNC_QUERY, '0, '0, '0, '0);
      send(FUNC_CLEAR, '0, '0, '0, '0);
      send(FUNC_TICK, '0, '0, '0, 32'd1);
      send(FUNC_REMOVE, 16'h1234, '0, '0, '0);
      send(FUNC_APPLY, '0, '0, '0, '0);
      send(FUNC_APPLY, '1, '1, '1, '0);
      send(FUNC_QUERY, '1, '0, '0, '0);
      send(FUNC_APPLY, '0, 32'h0001_0000, 32'h5A5A_A5A5, '0);   // re-apply moves to end
      send(FUNC_APPLY, 16'h0007, '0, 32'h0000_0001, '0);
      send(FUNC_TICK, '0, '0, '0, '0);                          // zero time expires
      send(FUNC_REMOVE, '1, '0, '0, '0);
      send(FUNC_UNUSED_FIRST, 16'h0003, '1, '1, '1);
      send(FUNC_UNUSED_LAST, 16'h0003, '1, '1, '1);
      for (int i = 0; i < TABLE_DEPTH - 1; i++)
         send(FUNC_APPLY, 16'h0100 + 16'(i), 32'h0002_0000 + 32'(i), $urandom, '0);
      send(FUNC_APPLY, 16'h0200, 32'h0001_0000, $urandom, '0);  // table full
      send(FUNC_APPLY, 16'h0105, 32'h0004_0000, $urandom, '0);  // present key on full table
      send(FUNC_QUERY, 16'h0200, '0, '0, '0);
      send(FUNC_TICK, '0, '0, '0, '1);                          // everything expires
      wait_drained();

      queue_random(30);
      wait_drained();

      write_authority(1'b0);
      send(FUNC_APPLY, 16'h0F0F, 32'h0001_0000, $urandom, '0);
      send(FUNC_CLEAR, '0, '0, '0, '0);
      send(FUNC_TICK, '0, '0, '0, '1);
      send(FUNC_REMOVE, KEY_POOL_BASE, '0, '0, '0);
      queue_random(8);
      wait_drained();

      write_authority(1'b1);
      want_long_hold = 1'b1;
      queue_random(20);
      while (pending_reqs.size() != 0) @(negedge clock);
      no_idle = 1'b1;
      queue_random(12);
      wait_drained();

      $display("Covered %0d requests over authority on/off/on, incl. full table and expiry.",
               reqs_accepted);
      $display("Checked %0d events: %0d removals, %0d full rejections, %0d query answers.",
               events_checked, removals_seen, full_seen, queries_seen);
      if (fail_count == 0) begin
         $display("** keyed_expiry_timer_table: PASSED **");
      end else begin
         $display("** keyed_expiry_timer_table: FAILED **");
      end
      $finish;
   end

endmodule
